// ----- rtl/rgbl_pkg.sv -----
// Shared types and codes for the rectilinear grid bilinear lookup.
// No dependencies; every other file but rgbl_if.sv and rgbl_tb_if.sv refers to it by scoped names.
package rgbl_pkg;

    // item modes
    localparam logic [1:0] MODE_LOAD_X  = 2'd0;
    localparam logic [1:0] MODE_LOAD_Y  = 2'd1;
    localparam logic [1:0] MODE_LOAD_H  = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    // configuration register indexes (byte address = 4 * index)
    localparam logic REG_X_COUNT = 1'b0;
    localparam logic REG_Y_COUNT = 1'b1;

    localparam logic [8:0] COUNT_RESET = 9'd256;

    typedef struct packed {
        logic               start;
        logic signed [32:0] num;
        logic signed [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] new_z;
        logic               inside_res;
    } res_t;

endpackage

// ----- rtl/rgbl_if.sv -----
// Stream interfaces for the lookup's item and result channels.
// Depends on nothing; follows rgbl_pkg in compile order.
interface rgbl_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [15:0]        load_index;
    logic signed [31:0] load_value;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;

    modport source (output valid, mode, load_index, load_value, node_x, node_y, node_z,
                    input ready);
    modport sink   (input valid, mode, load_index, load_value, node_x, node_y, node_z,
                    output ready);
endinterface

interface rgbl_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_z;
    logic               inside_res;

    modport source (output valid, new_z, inside_res, input ready);
    modport sink   (input valid, new_z, inside_res, output ready);
endinterface

// ----- rtl/rgbl_div.sv -----
// Radix-2 restoring divider for the interval fractions, one quotient bit a cycle.
// Depends on rgbl_pkg (div_req_t).
module rgbl_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rgbl_pkg::div_req_t dreq,
    output logic              done,
    output logic [FRAC_BITS:0] quo
);

    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [FRAC_BITS:0] SCALE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic                 busy_reg, rnd_reg, done_reg;
    logic [CW-1:0]        cnt_reg;
    logic [31:0]          rem_reg, den_reg;
    logic [FRAC_BITS:0]   q_reg;
    logic [32:0]          rem2;
    logic                 qbit;
    logic [32:0]          rsum;

    assign rem2 = {rem_reg, 1'b0};
    assign qbit = (rem2 >= {1'b0, den_reg});
    assign rsum = {1'b0, rem_reg} + {2'b00, den_reg[31:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (dreq.start)
            begin
                // non-positive width or offset gives zero, offset at or past width gives one
                if (dreq.den[32] || dreq.den == '0 || dreq.num[32] || dreq.num == '0)
                begin
                    q_reg    <= '0;
                    done_reg <= 1'b1;
                end
                else if (dreq.num >= dreq.den)
                begin
                    q_reg    <= SCALE;
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= dreq.num[31:0];
                    den_reg  <= dreq.den[31:0];
                    q_reg    <= '0;
                    cnt_reg  <= CW'(FRAC_BITS);
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? 32'(rem2 - {1'b0, den_reg}) : rem_reg << 1;
                q_reg   <= {q_reg[FRAC_BITS-1:0], qbit};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    rnd_reg  <= 1'b1;
                end
            end
            else if (rnd_reg)
            begin
                // round half up on the remainder
                q_reg    <= q_reg + (FRAC_BITS + 1)'(rsum >= {1'b0, den_reg});
                rnd_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ----- rtl/rgbl_core.sv -----
// Grid memories and the query sequencer: axis searches, fractions, weighted sums.
// Depends on rgbl_pkg, rgbl_if and rgbl_div.
module rgbl_core #(
    parameter int MAX_X_POINTS = 256,
    parameter int MAX_Y_POINTS = 256,
    parameter int FRAC_BITS    = 16,
    parameter int CXW          = 9,
    parameter int CYW          = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    rgbl_in_if.sink            req,
    input  logic [CXW-1:0]     cx,
    input  logic [CYW-1:0]     cy,
    output rgbl_pkg::res_t     res,
    input  logic               res_ready
);

    localparam int XIW = (MAX_X_POINTS > 2) ? $clog2(MAX_X_POINTS) : 1;
    localparam int YIW = (MAX_Y_POINTS > 2) ? $clog2(MAX_Y_POINTS) : 1;
    localparam int AW  = (XIW > YIW) ? XIW : YIW;
    localparam int HDEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int HAW = $clog2(HDEPTH);
    localparam int PW  = 32 + FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] SCALE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_END0  = 5'd1;
    localparam logic [4:0] ST_END1  = 5'd2;
    localparam logic [4:0] ST_END2  = 5'd3;
    localparam logic [4:0] ST_CHK   = 5'd4;
    localparam logic [4:0] ST_MID   = 5'd5;
    localparam logic [4:0] ST_DGO   = 5'd6;
    localparam logic [4:0] ST_DWAIT = 5'd7;
    localparam logic [4:0] ST_ROW   = 5'd8;
    localparam logic [4:0] ST_BASE  = 5'd9;
    localparam logic [4:0] ST_HRD   = 5'd10;
    localparam logic [4:0] ST_HMUL  = 5'd11;
    localparam logic [4:0] ST_HACC  = 5'd12;
    localparam logic [4:0] ST_V0    = 5'd13;
    localparam logic [4:0] ST_V1    = 5'd14;
    localparam logic [4:0] ST_V2    = 5'd15;
    localparam logic [4:0] ST_FIN   = 5'd16;
    localparam logic [4:0] ST_EMIT  = 5'd17;

    logic signed [31:0] x_mem [MAX_X_POINTS];
    logic signed [31:0] y_mem [MAX_Y_POINTS];
    logic signed [31:0] h_mem [HDEPTH];
    logic signed [31:0] x_rd, y_rd, h_rd;

    logic [4:0]         state_reg;
    logic               axis_reg;
    logic [AW-1:0]      lo_reg, hi_reg, mid_reg;
    logic signed [31:0] lov_reg, hiv_reg;
    logic [AW-1:0]      ix_reg, iy_reg;
    logic signed [31:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic signed [31:0] nx_reg, ny_reg, nz_reg;
    logic [FRAC_BITS:0] u_reg, v_reg;
    logic [HAW-1:0]     bmul_reg, base_reg;
    logic [1:0]         k_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW:0]   acc_reg;
    logic signed [31:0] r0_reg, r1_reg, hval_reg;
    logic signed [31:0] resz_reg;
    logic               resin_reg;

    logic               acc_in;
    logic signed [31:0] coord, rdata, a0, a1;
    logic [AW-1:0]      cnt_m1, mid_c, rd_idx;
    logic [HAW-1:0]     h_raddr;
    logic [FRAC_BITS:0] wgt;
    logic signed [PW:0] acc_sum;
    logic signed [32:0] zsum;
    rgbl_pkg::div_req_t dreq;
    logic               div_done;
    logic [FRAC_BITS:0] div_q;

    assign acc_in    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign coord  = axis_reg ? ny_reg : nx_reg;
    assign rdata  = axis_reg ? y_rd : x_rd;
    assign cnt_m1 = axis_reg ? AW'(cy - CYW'(1)) : AW'(cx - CXW'(1));
    assign mid_c  = AW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign a0     = axis_reg ? y0_reg : x0_reg;
    assign a1     = axis_reg ? y1_reg : x1_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_END0: rd_idx = '0;
            ST_END1: rd_idx = cnt_m1;
            ST_CHK:  rd_idx = mid_c;
            default: rd_idx = mid_reg;
        endcase
    end

    assign h_raddr = base_reg + (k_reg[1] ? HAW'(cx) : HAW'(0)) + HAW'(k_reg[0]);
    assign wgt     = k_reg[0] ? u_reg : SCALE - u_reg;
    assign acc_sum = (k_reg[0] ? acc_reg : HALF) + (PW + 1)'(prod_reg);
    assign zsum    = {nz_reg[31], nz_reg} + {hval_reg[31], hval_reg};

    assign dreq.start = (state_reg == ST_DGO);
    assign dreq.num   = {coord[31], coord} - {a0[31], a0};
    assign dreq.den   = {a1[31], a1} - {a0[31], a0};

    rgbl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .dreq (dreq),
        .done (div_done),
        .quo  (div_q)
    );

    // loads and queries never overlap, so a read never races a write to its entry
    always_ff @(posedge clk)
    begin
        if (acc_in && req.mode == rgbl_pkg::MODE_LOAD_X && 32'(req.load_index) < MAX_X_POINTS)
            x_mem[XIW'(req.load_index)] <= req.load_value;
        x_rd <= x_mem[XIW'(rd_idx)];
    end

    always_ff @(posedge clk)
    begin
        if (acc_in && req.mode == rgbl_pkg::MODE_LOAD_Y && 32'(req.load_index) < MAX_Y_POINTS)
            y_mem[YIW'(req.load_index)] <= req.load_value;
        y_rd <= y_mem[YIW'(rd_idx)];
    end

    always_ff @(posedge clk)
    begin
        if (acc_in && req.mode == rgbl_pkg::MODE_LOAD_H && 32'(req.load_index) < HDEPTH)
            h_mem[HAW'(req.load_index)] <= req.load_value;
        h_rd <= h_mem[h_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc_in && req.mode == rgbl_pkg::MODE_QUERY)
                    begin
                        nx_reg    <= req.node_x;
                        ny_reg    <= req.node_y;
                        nz_reg    <= req.node_z;
                        axis_reg  <= 1'b0;
                        state_reg <= ST_END0;
                    end
                end
                ST_END0: state_reg <= ST_END1;
                ST_END1:
                begin
                    lov_reg   <= rdata;
                    state_reg <= ST_END2;
                end
                ST_END2:
                begin
                    if (coord < lov_reg || coord > rdata)
                    begin
                        resz_reg  <= nz_reg;
                        resin_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        hiv_reg   <= rdata;
                        lo_reg    <= '0;
                        hi_reg    <= cnt_m1;
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    if (hi_reg - lo_reg > AW'(1))
                    begin
                        mid_reg   <= mid_c;
                        state_reg <= ST_MID;
                    end
                    else if (!axis_reg)
                    begin
                        ix_reg    <= lo_reg;
                        x0_reg    <= lov_reg;
                        x1_reg    <= hiv_reg;
                        axis_reg  <= 1'b1;
                        state_reg <= ST_END0;
                    end
                    else
                    begin
                        iy_reg    <= lo_reg;
                        y0_reg    <= lov_reg;
                        y1_reg    <= hiv_reg;
                        axis_reg  <= 1'b0;
                        state_reg <= ST_DGO;
                    end
                end
                ST_MID:
                begin
                    // p[lo] <= c holds throughout, so only c < p[mid] decides
                    if (coord < rdata)
                    begin
                        hi_reg  <= mid_reg;
                        hiv_reg <= rdata;
                    end
                    else
                    begin
                        lo_reg  <= mid_reg;
                        lov_reg <= rdata;
                    end
                    state_reg <= ST_CHK;
                end
                ST_DGO: state_reg <= ST_DWAIT;
                ST_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (!axis_reg)
                        begin
                            u_reg     <= div_q;
                            axis_reg  <= 1'b1;
                            state_reg <= ST_DGO;
                        end
                        else
                        begin
                            v_reg     <= div_q;
                            state_reg <= ST_ROW;
                        end
                    end
                end
                ST_ROW:
                begin
                    bmul_reg  <= HAW'(iy_reg) * HAW'(cx);
                    state_reg <= ST_BASE;
                end
                ST_BASE:
                begin
                    base_reg  <= bmul_reg + HAW'(ix_reg);
                    k_reg     <= '0;
                    state_reg <= ST_HRD;
                end
                ST_HRD: state_reg <= ST_HMUL;
                ST_HMUL:
                begin
                    prod_reg  <= PW'($signed(h_rd)) * PW'($signed({1'b0, wgt}));
                    state_reg <= ST_HACC;
                end
                ST_HACC:
                begin
                    acc_reg <= acc_sum;
                    if (k_reg == 2'd1)
                        r0_reg <= acc_sum[FRAC_BITS+31:FRAC_BITS];
                    if (k_reg == 2'd3)
                        r1_reg <= acc_sum[FRAC_BITS+31:FRAC_BITS];
                    k_reg     <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd3) ? ST_V0 : ST_HRD;
                end
                ST_V0:
                begin
                    prod_reg  <= PW'($signed(r0_reg)) * PW'($signed({1'b0, SCALE - v_reg}));
                    state_reg <= ST_V1;
                end
                ST_V1:
                begin
                    acc_reg   <= HALF + (PW + 1)'(prod_reg);
                    prod_reg  <= PW'($signed(r1_reg)) * PW'($signed({1'b0, v_reg}));
                    state_reg <= ST_V2;
                end
                ST_V2:
                begin
                    hval_reg  <= 32'((acc_reg + (PW + 1)'(prod_reg)) >>> FRAC_BITS);
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (zsum[32] != zsum[31])
                        resz_reg <= zsum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    else
                        resz_reg <= zsum[31:0];
                    resin_reg <= 1'b1;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (res_ready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res.valid      = (state_reg == ST_EMIT);
    assign res.new_z      = resz_reg;
    assign res.inside_res = resin_reg;

endmodule

// ----- rtl/rectilinear_grid_bilinear_lookup_top.sv -----
// Top level: APB count registers, count clamping, result output register.
// Depends on rgbl_pkg, rgbl_if, rgbl_core.
//
//  channel | dir | beat / access
//  --------+-----+-----------------------------------------------
//  req     | in  | mode, load_index, load_value, node_x/y/z
//  rsp     | out | new_z, inside_res (one beat per query)
//  apb     | in  | x_count at 0x0, y_count at 0x4
//
// A query's length is set by the one-port axis memory searches and the bit-serial
// divider; the core takes no new item until the query's result has been handed on.
// Reset clears control state only; grid memories are not cleared.
// A result waits in the output register while the next item is taken; a query that
// finishes while it is still full holds until rsp is ready.
module rectilinear_grid_bilinear_lookup_top #(
    parameter int MAX_X_POINTS = 256,
    parameter int MAX_Y_POINTS = 256,
    parameter int FRAC_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rgbl_in_if.sink     req,
    rgbl_out_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CXW = $clog2(MAX_X_POINTS + 1);
    localparam int CYW = $clog2(MAX_Y_POINTS + 1);

    logic [8:0]         x_count_reg, y_count_reg;
    logic [CXW-1:0]     cx;
    logic [CYW-1:0]     cy;
    logic               wr_en;
    rgbl_pkg::res_t     core_res;
    logic               core_res_ready;
    logic               out_valid_reg;
    logic signed [31:0] out_z_reg;
    logic               out_in_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg <= rgbl_pkg::COUNT_RESET;
            y_count_reg <= rgbl_pkg::COUNT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == rgbl_pkg::REG_X_COUNT)
                x_count_reg <= pwdata[8:0];
            else
                y_count_reg <= pwdata[8:0];
        end
    end

    assign prdata = (paddr[2] == rgbl_pkg::REG_Y_COUNT) ? {23'd0, y_count_reg}
                                                        : {23'd0, x_count_reg};

    always_comb
    begin
        priority if (x_count_reg < 9'd2)
            cx = CXW'(2);
        else if (32'(x_count_reg) > MAX_X_POINTS)
            cx = CXW'(MAX_X_POINTS);
        else
            cx = CXW'(x_count_reg);
        priority if (y_count_reg < 9'd2)
            cy = CYW'(2);
        else if (32'(y_count_reg) > MAX_Y_POINTS)
            cy = CYW'(MAX_Y_POINTS);
        else
            cy = CYW'(y_count_reg);
    end

    rgbl_core #(
        .MAX_X_POINTS(MAX_X_POINTS),
        .MAX_Y_POINTS(MAX_Y_POINTS),
        .FRAC_BITS   (FRAC_BITS),
        .CXW         (CXW),
        .CYW         (CYW)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cx       (cx),
        .cy       (cy),
        .res      (core_res),
        .res_ready(core_res_ready)
    );

    assign core_res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_res.valid && core_res_ready)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_res.valid && core_res_ready)
        begin
            out_z_reg  <= core_res.new_z;
            out_in_reg <= core_res.inside_res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.new_z      = out_z_reg;
    assign rsp.inside_res = out_in_reg;

    a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
        core_res.valid && core_res_ready |=> out_valid_reg)
        else $error("result beat not captured in output register");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && core_res.valid))
        else $error("input ready while a result is pending");

    a_xcount_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && paddr[2] == rgbl_pkg::REG_X_COUNT |=> x_count_reg == $past(pwdata[8:0]))
        else $error("x_count write lost");

    a_clamp_low: assert property (@(posedge clk) disable iff (!rst_n)
        cx >= CXW'(2) && cy >= CYW'(2))
        else $error("clamped count below two");

endmodule

// ----- verif/rgbl_tb_if.sv -----
`timescale 1ns / 100ps
// Testbench-side records for the lookup's item and result channels.
// Depends on nothing; the channel interfaces come from rtl/rgbl_if.sv.
package rgbl_tb_pkg;

    typedef struct {
        logic [1:0]         mode;
        logic [15:0]        load_index;
        logic signed [31:0] load_value;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] node_z;
        bit                 fixed;      // typed-in answer below replaces the predictor's
        logic signed [31:0] fixed_z;
        logic               fixed_in;
    } grid_item_t;

    typedef struct {
        logic signed [31:0] new_z;
        logic               inside_res;
    } height_res_t;

endpackage

// ----- verif/tb_rectilinear_grid_bilinear_lookup_top.sv -----
`timescale 1ns / 100ps
// Testbench for rectilinear_grid_bilinear_lookup_top: directed table, then random phases
// over several count settings, results checked against a bilinear height predictor or typed-in answers.
// Depends on rgbl_pkg, rgbl_if, rgbl_tb_pkg and the RTL.
module tb_rectilinear_grid_bilinear_lookup_top;

    localparam int  MAXP       = 256;
    localparam int  FB         = 16;
    localparam longint SCALE   = 64'sd1 << FB;
    localparam int  LIMIT      = 20000;
    localparam int  DRAIN      = 200;
    localparam int  HOLD_LEN   = 400;
    localparam int  NPHASE     = 4;
    localparam int  NQUERY     = 25;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgbl_in_if  req_if ();
    rgbl_out_if rsp_if ();

    rectilinear_grid_bilinear_lookup_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic signed [31:0] x_pts [MAXP];
    logic signed [31:0] y_pts [MAXP];
    logic signed [31:0] h_tab [MAXP*MAXP];
    logic [8:0]         x_count_q;
    logic [8:0]         y_count_q;

    // stimulus generation copies of the axes
    logic signed [31:0] gen_x [MAXP];
    logic signed [31:0] gen_y [MAXP];

    rgbl_tb_pkg::grid_item_t  stim_q [$];
    rgbl_tb_pkg::height_res_t z_expected_q [$];
    rgbl_tb_pkg::grid_item_t  cur_item;
    bit          req_took;
    bit          hold_rsp;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    int          err_count;

    always #10 clk = ~clk;

    task automatic report(input string what);
        err_count++;
        $display("mismatch: %s", what);
    endtask

    function automatic int eff_count(input logic [8:0] v);
        if (v < 2) return 2;
        if (v > MAXP) return MAXP;
        return v;
    endfunction

    function automatic logic signed [31:0] axis_pt(input bit is_x, input int i);
        return is_x ? x_pts[i] : y_pts[i];
    endfunction

    function automatic bit find_cell(input bit is_x, input int cnt,
                                     input logic signed [31:0] c, output int idx);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = cnt - 1;
        idx = 0;
        if (c < axis_pt(is_x, 0) || c > axis_pt(is_x, cnt - 1)) return 0;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (axis_pt(is_x, lo) <= c && c < axis_pt(is_x, mid)) hi = mid;
            else lo = mid;
        end
        idx = lo;
        return 1;
    endfunction

    function automatic longint frac_of(input longint lo, input longint hi, input longint c);
        longint d;
        longint num;
        d = hi - lo;
        num = c - lo;
        if (d <= 0 || num <= 0) return 0;
        if (num >= d) return SCALE;
        return ((num << FB) + d / 2) / d;
    endfunction

    // floor((w + S/2) / S)
    function automatic longint round_half_up(input longint w);
        return (w + SCALE / 2) >>> FB;
    endfunction

    // apply one accepted beat; returns 1 when it yields a result
    function automatic bit grid_predict(input rgbl_tb_pkg::grid_item_t it,
                                        output rgbl_tb_pkg::height_res_t r);
        int cx;
        int cy;
        int ix;
        int iy;
        int r0i;
        int r1i;
        longint u;
        longint v;
        longint r0;
        longint r1;
        longint h;
        longint z;
        r.new_z = it.node_z;
        r.inside_res = 1'b0;
        case (it.mode)
            rgbl_pkg::MODE_LOAD_X: begin
                if (it.load_index < MAXP) x_pts[it.load_index] = it.load_value;
                return 0;
            end
            rgbl_pkg::MODE_LOAD_Y: begin
                if (it.load_index < MAXP) y_pts[it.load_index] = it.load_value;
                return 0;
            end
            rgbl_pkg::MODE_LOAD_H: begin
                h_tab[it.load_index] = it.load_value;
                return 0;
            end
            default: ;
        endcase
        cx = eff_count(x_count_q);
        cy = eff_count(y_count_q);
        if (!find_cell(1'b1, cx, it.node_x, ix) || !find_cell(1'b0, cy, it.node_y, iy))
            return 1;
        u = frac_of(x_pts[ix], x_pts[ix+1], it.node_x);
        v = frac_of(y_pts[iy], y_pts[iy+1], it.node_y);
        r0i = iy * cx + ix;
        r1i = (iy + 1) * cx + ix;
        r0 = round_half_up(longint'(h_tab[r0i]) * (SCALE - u) + longint'(h_tab[r0i+1]) * u);
        r1 = round_half_up(longint'(h_tab[r1i]) * (SCALE - u) + longint'(h_tab[r1i+1]) * u);
        h = round_half_up(r0 * (SCALE - v) + r1 * v);
        z = longint'(it.node_z) + h;
        if (z > 64'sd2147483647) z = 64'sd2147483647;
        if (z < -64'sd2147483648) z = -64'sd2147483648;
        r.new_z = z[31:0];
        r.inside_res = 1'b1;
        return 1;
    endfunction

    function automatic rgbl_tb_pkg::grid_item_t mk(input logic [1:0] m,
                                                   input logic [15:0] li,
                                                   input logic signed [31:0] lv,
                                                   input logic signed [31:0] nx,
                                                   input logic signed [31:0] ny,
                                                   input logic signed [31:0] nz);
        rgbl_tb_pkg::grid_item_t it;
        it.mode = m;
        it.load_index = li;
        it.load_value = lv;
        it.node_x = nx;
        it.node_y = ny;
        it.node_z = nz;
        it.fixed = 0;
        it.fixed_z = 0;
        it.fixed_in = 0;
        return it;
    endfunction

    function automatic rgbl_tb_pkg::grid_item_t mk_fixed(input logic signed [31:0] nx,
                                                         input logic signed [31:0] ny,
                                                         input logic signed [31:0] nz,
                                                         input logic signed [31:0] ez,
                                                         input logic ein);
        rgbl_tb_pkg::grid_item_t it;
        it = mk(rgbl_pkg::MODE_QUERY, 16'($urandom), $urandom, nx, ny, nz);
        it.fixed = 1;
        it.fixed_z = ez;
        it.fixed_in = ein;
        return it;
    endfunction

    // ---------------- channel driving and monitoring ----------------

    always @(posedge clk) begin
        rgbl_tb_pkg::height_res_t r;
        rgbl_tb_pkg::height_res_t e;
        req_took = req_if.valid && req_if.ready;
        if (req_took) begin
            if (grid_predict(cur_item, r)) begin
                if (cur_item.fixed) begin
                    r.new_z = cur_item.fixed_z;
                    r.inside_res = cur_item.fixed_in;
                end
                z_expected_q.push_back(r);
            end
        end
        if (rsp_if.valid && rsp_if.ready) begin
            if (z_expected_q.size() == 0) begin
                report($sformatf("result with nothing pending, new_z=%0d", rsp_if.new_z));
            end
            else begin
                e = z_expected_q.pop_front();
                if (rsp_if.new_z !== e.new_z)
                    report($sformatf("new_z got %0d want %0d", rsp_if.new_z, e.new_z));
                if (rsp_if.inside_res !== e.inside_res)
                    report($sformatf("inside_res got %0b want %0b",
                                     rsp_if.inside_res, e.inside_res));
            end
        end
        if (req_took || (rsp_if.valid && rsp_if.ready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk) begin
        if (rst_n && (!req_if.valid || req_took)) begin
            if (stim_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_item = stim_q.pop_front();
                req_if.valid      <= 1'b1;
                req_if.mode       <= cur_item.mode;
                req_if.load_index <= cur_item.load_index;
                req_if.load_value <= cur_item.load_value;
                req_if.node_x     <= cur_item.node_x;
                req_if.node_y     <= cur_item.node_y;
                req_if.node_z     <= cur_item.node_z;
            end
            else begin
                req_if.valid <= 1'b0;
            end
        end
        rsp_if.ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        wait (quiet_cycles >= LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------- configuration ----------------

    task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] d,
                              output logic [31:0] rd);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_counts(input logic [31:0] xv, input logic [31:0] yv);
        logic [31:0] rd;
        logic [2:0]  ax;
        logic [2:0]  ay;
        ax = {rgbl_pkg::REG_X_COUNT, 2'b00};
        ay = {rgbl_pkg::REG_Y_COUNT, 2'b00};
        apb_access(1'b1, ax, xv, rd);
        apb_access(1'b1, ay, yv, rd);
        x_count_q = xv[8:0];
        y_count_q = yv[8:0];
        apb_access(1'b0, ax, 32'd0, rd);
        if (rd[8:0] !== x_count_q) report($sformatf("x_count read %0d", rd));
        apb_access(1'b0, ay, 32'd0, rd);
        if (rd[8:0] !== y_count_q) report($sformatf("y_count read %0d", rd));
    endtask

    task automatic wait_idle();
        while (stim_q.size() > 0 || req_if.valid || z_expected_q.size() > 0)
            @(posedge clk);
        // loads leave nothing to wait on; let any query still in flight drain
        repeat (150) @(posedge clk);
    endtask

    // start once a query is in flight so the block fills while the sender keeps offering
    task automatic hold_receiver();
        wait (z_expected_q.size() > 0);
        hold_rsp = 1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_rsp = 0;
    endtask

    // ---------------- random phases ----------------

    task automatic build_axis(input bit is_x, input int cnt);
        int kind;
        longint p;
        logic signed [31:0] v;
        kind = $urandom_range(0, 9);
        p = longint'($signed($urandom_range(0, 32'h7fff_ffff))) - 64'sd1073741824;
        for (int i = 0; i < cnt; i++) begin
            if (kind == 9) v = $urandom;              // unsorted
            else begin
                v = p[31:0];
                if (kind >= 7 && $urandom_range(0, 2) == 0) p = p;   // repeat a point
                else p = p + $urandom_range(1, (kind == 0) ? 32'h0010_0000 : 2000);
            end
            if (is_x) gen_x[i] = v;
            else gen_y[i] = v;
            stim_q.push_back(mk(is_x ? rgbl_pkg::MODE_LOAD_X : rgbl_pkg::MODE_LOAD_Y,
                                16'(i), v, $urandom, $urandom, $urandom));
        end
    endtask

    function automatic logic signed [31:0] pick_coord(input bit is_x, input int cnt);
        longint lo_v;
        longint hi_v;
        longint c;
        int k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            k = $urandom_range(0, cnt - 2);
            lo_v = is_x ? gen_x[k] : gen_y[k];
            hi_v = is_x ? gen_x[k+1] : gen_y[k+1];
            if (hi_v > lo_v) c = lo_v + (longint'($urandom) % (hi_v - lo_v + 1));
            else c = lo_v;
        end
        else if (r < 80) begin
            k = $urandom_range(0, cnt - 1);
            c = is_x ? gen_x[k] : gen_y[k];
        end
        else if (r < 88) begin
            if ($urandom_range(0, 1)) c = longint'(is_x ? gen_x[0] : gen_y[0]) - 1;
            else c = longint'(is_x ? gen_x[cnt-1] : gen_y[cnt-1]) + 1;
        end
        else if (r < 93) begin
            c = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
        end
        else begin
            c = longint'($signed($urandom));
        end
        if (c > 64'sd2147483647) c = 64'sd2147483647;
        if (c < -64'sd2147483648) c = -64'sd2147483648;
        return c[31:0];
    endfunction

    function automatic logic signed [31:0] pick_height();
        if ($urandom_range(0, 1)) return $urandom;
        return $signed($urandom_range(0, 200000)) - 100000;
    endfunction

    task automatic run_phase(input int ph, input logic [31:0] xr, input logic [31:0] yr);
        int cx;
        int cy;
        int r;
        logic signed [31:0] nz;
        wait_idle();
        set_counts(xr, yr);
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
        cx = eff_count(xr[8:0]);
        cy = eff_count(yr[8:0]);
        build_axis(1'b1, cx);
        build_axis(1'b0, cy);
        for (int i = 0; i < cx * cy; i++)
            stim_q.push_back(mk(rgbl_pkg::MODE_LOAD_H, 16'(i), pick_height(), $urandom,
                                $urandom, $urandom));
        if (ph == 2) fork hold_receiver(); join_none
        for (int q = 0; q < NQUERY; q++) begin
            r = $urandom_range(0, 99);
            // stray loads: mostly out-of-range axis indexes, height rewrites in use
            if (r < 8)
                stim_q.push_back(mk(rgbl_pkg::MODE_LOAD_X + 2'($urandom_range(0, 1)),
                                    16'($urandom), $urandom, $urandom, $urandom,
                                    $urandom));
            else if (r < 15)
                stim_q.push_back(mk(rgbl_pkg::MODE_LOAD_H,
                                    16'($urandom_range(0, cx * cy - 1)),
                                    pick_height(), $urandom, $urandom, $urandom));
            nz = $urandom_range(0, 2) ? $urandom : ($signed($urandom_range(0, 4000)) - 2000);
            stim_q.push_back(mk(rgbl_pkg::MODE_QUERY, 16'($urandom), $urandom,
                                pick_coord(1'b1, cx), pick_coord(1'b0, cy), nz));
        end
    endtask

    // ---------------- main sequence ----------------

    initial begin
        rgbl_tb_pkg::grid_item_t table_rows [$];
        logic [31:0] xs [NPHASE];
        logic [31:0] ys [NPHASE];
        clk = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 0;
        req_if.mode = rgbl_pkg::MODE_LOAD_X;
        req_if.load_index = '0;
        req_if.load_value = '0;
        req_if.node_x = '0;
        req_if.node_y = '0;
        req_if.node_z = '0;
        rsp_if.ready = 0;
        hold_rsp = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        err_count = 0;
        req_took = 0;
        x_count_q = rgbl_pkg::COUNT_RESET;
        y_count_q = rgbl_pkg::COUNT_RESET;
        for (int i = 0; i < MAXP; i++) begin
            x_pts[i] = 0;
            y_pts[i] = 0;
        end
        for (int i = 0; i < MAXP * MAXP; i++) h_tab[i] = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // counts below two act as two: a unit grid, 256 on a side
        set_counts(32'd0, 32'd1);
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_X, 16'd0, 32'sd0, 0, 0, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_X, 16'd1, 32'sd256, 0, 0, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_Y, 16'd0, 32'sd0, 0, 0, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_Y, 16'd1, 32'sd256, 0, 0, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_H, 16'd0, 32'sd256, 0, 0, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_H, 16'd1, 32'sd512, 0, 0, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_H, 16'd2, 32'sd768, 0, 0, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_H, 16'd3, 32'sd1024, 0, 0, 0));
        table_rows.push_back(mk_fixed(0, 0, 0, 32'sd256, 1'b1));
        table_rows.push_back(mk_fixed(256, 256, 100, 32'sd1124, 1'b1));
        table_rows.push_back(mk(rgbl_pkg::MODE_QUERY, 16'hffff, 32'hffff_ffff, 128, 128, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_QUERY, 16'h0, 32'h0, 64, 200, -32'sd77));
        table_rows.push_back(mk_fixed(-1, 0, 55, 32'sd55, 1'b0));
        table_rows.push_back(mk_fixed(257, 0, -9, -32'sd9, 1'b0));
        table_rows.push_back(mk_fixed(0, 257, 3, 32'sd3, 1'b0));
        table_rows.push_back(mk_fixed(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                      32'h8000_0000, 1'b0));
        table_rows.push_back(mk_fixed(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                      32'h7fff_ffff, 1'b0));
        // saturate high at a corner
        table_rows.push_back(mk_fixed(0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
        // out-of-range axis indexes are dropped
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_X, 16'd300, 32'sd5, 0, 0, 0));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_Y, 16'hffff, 32'sd5, 0, 0, 0));
        table_rows.push_back(mk_fixed(256, 0, 0, 32'sd512, 1'b1));
        // saturate low at a corner
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_H, 16'd0, -32'sd256, 0, 0, 0));
        table_rows.push_back(mk_fixed(0, 0, 32'h8000_0000, 32'h8000_0000, 1'b1));
        table_rows.push_back(mk(rgbl_pkg::MODE_LOAD_H, 16'hffff, 32'h7fff_ffff, 0, 0, 0));
        foreach (table_rows[i]) stim_q.push_back(table_rows[i]);

        // a count above the maximum acts as the maximum: the full-depth search phase
        xs = '{32'd3, 32'd2, 32'd300, 32'd5};
        ys = '{32'd3, 32'd2, 32'd2, 32'd4};
        for (int ph = 0; ph < NPHASE; ph++) run_phase(ph, xs[ph], ys[ph]);

        while (stim_q.size() > 0 || req_if.valid || z_expected_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (z_expected_q.size() != 0) report("results still pending at end");
        if (err_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
